[rtl/uast_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique address set table package
// Command, status and sequencer state types shared by the table logic and
// its checker.
// ----------------------------------------------------------------------------
package uast_pkg;

    typedef enum logic {
        CMD_REGISTER = 1'b0,
        CMD_DELETE   = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        STATUS_REGISTERED = 3'd0,
        STATUS_PRESENT    = 3'd1,
        STATUS_FULL       = 3'd2,
        STATUS_DELETED    = 3'd3,
        STATUS_NOT_FOUND  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_SHIFT_READ,
        ST_SHIFT_WRITE,
        ST_FINISH
    } seq_state_t;

    localparam int ADDR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

endpackage

[rtl/uast_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique address set table entry memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module uast_ram #(
    parameter int DEPTH = 100,
    parameter int IW    = 7
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/unique_address_set_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique address set table
// Ordered list of unique 8-bit addresses with register and compacting delete.
//
// Channel   Direction  tdata                           tuser
// s_        in         [7:0] address                   [0] command
// m_        out        [2:0] status, [9:3] entry_count  -
//
// One transaction is taken at a time; s_tready is high only when idle.
// The search visits one entry at a time through the single read port of the
// entry memory, each in a read and a compare state, and a delete then moves
// each later entry down one place through a shift read and a shift write state.
// The result sits in an output register, so a stalled m_ side holds the block
// only at the point where the next result would be loaded.
// Reset clears the count; memory contents need no clearing.
// ----------------------------------------------------------------------------
module unique_address_set_table_unit #(
    parameter int MAX_ENTRIES = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] address
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [9:3] entry_count
);

    import uast_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

    seq_state_t          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                found_reg, found_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic [CW-1:0]       ptr_inc;
    logic                out_free;
    logic                match;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic [7:0]          rd_data;

    assign ptr_inc  = ptr_reg + 1'b1;
    assign out_free = !m_valid_reg || m_tready;
    assign match    = (rd_data == addr_reg);

    uast_ram #(
        .DEPTH (MAX_ENTRIES),
        .IW    (IW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (cnt_reg == '0) ? ST_FINISH : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE: begin
                if (match) begin
                    state_next = (cmd_reg == CMD_DELETE) ? ST_SHIFT_READ : ST_FINISH;
                end else if (ptr_inc >= cnt_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_SHIFT_READ: begin
                state_next = (ptr_inc < cnt_reg) ? ST_SHIFT_WRITE : ST_FINISH;
            end
            ST_SHIFT_WRITE: begin
                state_next = ST_SHIFT_READ;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg[IW-1:0];
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg[IW-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = cmd_t'(s_tuser[0]);
                    addr_next  = s_tdata;
                    ptr_next   = '0;
                    found_next = 1'b0;
                end
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_COMPARE: begin
                if (match) begin
                    found_next = 1'b1;
                end else begin
                    ptr_next = ptr_inc;
                end
            end
            ST_SHIFT_READ: begin
                rd_en   = (ptr_inc < cnt_reg);
                rd_addr = ptr_inc[IW-1:0];
            end
            ST_SHIFT_WRITE: begin
                wr_en    = 1'b1;
                ptr_next = ptr_inc;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (cmd_reg == CMD_DELETE) begin
                        if (found_reg) begin
                            m_status_next = STATUS_DELETED;
                            cnt_next      = cnt_reg - 1'b1;
                        end else begin
                            m_status_next = STATUS_NOT_FOUND;
                        end
                    end else if (found_reg) begin
                        m_status_next = STATUS_PRESENT;
                    end else if (cnt_reg >= MAX_COUNT) begin
                        m_status_next = STATUS_FULL;
                    end else begin
                        m_status_next = STATUS_REGISTERED;
                        wr_en         = 1'b1;
                        wr_addr       = cnt_reg[IW-1:0];
                        wr_data       = addr_reg;
                        cnt_next      = cnt_reg + 1'b1;
                    end
                    m_count_next = COUNT_W'(cnt_next);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        ptr_reg      <= ptr_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_count_reg, m_status_reg};

endmodule

[rtl/uast_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique address set table checker
// Port-level properties of the table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module uast_chk #(
    parameter int MAX_ENTRIES = 100
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    import uast_pkg::*;

    logic [2:0] status;
    logic [6:0] count;

    assign status = m_tdata[2:0];
    assign count  = m_tdata[9:3];

    // A stalled result must hold its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An accepted transaction closes the input side in the cycle after it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before the current one finished");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (status == STATUS_REGISTERED) || (status == STATUS_PRESENT) ||
                     (status == STATUS_FULL) || (status == STATUS_DELETED) ||
                     (status == STATUS_NOT_FOUND))
        else $error("undefined status code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (MAX_ENTRIES > 127) || (count <= 7'(MAX_ENTRIES)))
        else $error("entry count above capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == STATUS_FULL) |-> count == 7'(MAX_ENTRIES))
        else $error("full status with a list that is not full");

endmodule

bind unique_address_set_table_unit uast_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_uast_chk (.*);
